FILE: rtl/bpfa_pkg.sv
// ----------------------------------------------------------------------------
// bpfa_pkg
// Shared types and constants of the bitmap page frame allocator: operation
// codes, bitmap word geometry, counter limits and the controller/datapath
// command and status bundles.
// ----------------------------------------------------------------------------
package bpfa_pkg;

    localparam int DEF_MAX_PAGES = 65536;

    // bitmap word geometry
    localparam int WORD_BITS = 32;
    localparam int BIT_W     = $clog2(WORD_BITS);

    // field and counter widths
    localparam int FUNC_W = 3;
    localparam int PAGE_W = 16;
    localparam int CNT_W  = 17;

    localparam logic [CNT_W-1:0] CNT_MAX     = '1;
    localparam logic [CNT_W-1:0] TOTAL_RESET = CNT_W'(65536);

    typedef logic [WORD_BITS-1:0] word_t;
    typedef logic [CNT_W-1:0]     cnt_t;

    typedef enum logic [FUNC_W-1:0] {
        FN_REQUEST   = 3'd0,
        FN_LOCK      = 3'd1,
        FN_FREE      = 3'd2,
        FN_RESERVE   = 3'd3,
        FN_UNRESERVE = 3'd4
    } bpfa_func_t;

    typedef struct packed {
        logic load;      // latch the accepted item
        logic start;     // set up the word range
        logic modify;    // read data valid: update word, record count change
        logic clear;     // reset sweep: zero one word
        logic out_load;  // capture the result item
    } bpfa_cmd_t;

    typedef struct packed {
        logic empty;     // nothing to scan for this item
        logic mod_done;  // last word of the range handled, or page found
        logic clr_last;  // sweep is at the last word
    } bpfa_status_t;

endpackage

FILE: rtl/bpfa_ctrl.sv
// ----------------------------------------------------------------------------
// bpfa_ctrl
// Sequencer of the allocator: runs the clearing sweep after reset, then for
// each item walks the bitmap word by word with a read and a modify step.
// Owns the input ready and the output valid.
// ----------------------------------------------------------------------------
module bpfa_ctrl
    import bpfa_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    output logic         m_tvalid,
    input  logic         m_tready,
    input  bpfa_status_t status,
    output bpfa_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_START,
        ST_READ,
        ST_MODIFY,
        ST_SETTLE,
        ST_DONE
    } state_t;

    state_t state_reg;
    logic   m_valid_reg;

    always_comb begin
        cmd.load     = (state_reg == ST_IDLE) && s_tvalid;
        cmd.start    = (state_reg == ST_START);
        cmd.modify   = (state_reg == ST_MODIFY);
        cmd.clear    = (state_reg == ST_CLEAR);
        cmd.out_load = (state_reg == ST_DONE) && (!m_valid_reg || m_tready);
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_CLEAR: begin
                    if (status.clr_last) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (s_tvalid) begin
                        state_reg <= ST_START;
                    end
                end
                ST_START: begin
                    state_reg <= status.empty ? ST_DONE : ST_READ;
                end
                ST_READ: begin
                    state_reg <= ST_MODIFY;
                end
                ST_MODIFY: begin
                    state_reg <= status.mod_done ? ST_SETTLE : ST_READ;
                end
                // let the last count change land before the result is taken
                ST_SETTLE: begin
                    state_reg <= ST_DONE;
                end
                ST_DONE: begin
                    if (!m_valid_reg || m_tready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: rtl/bpfa_datapath.sv
// ----------------------------------------------------------------------------
// bpfa_datapath
// Bitmap memory, search hint, page counters and result register. Each
// modify step masks one bitmap word to the active range, sets or clears
// bits, finds the lowest affected bit and counts the changed bits.
// ----------------------------------------------------------------------------
module bpfa_datapath
    import bpfa_pkg::*;
#(
    parameter int MAX_PAGES = DEF_MAX_PAGES
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_valid,
    input  logic [CNT_W-1:0]  cfg_data,
    input  logic [FUNC_W-1:0] in_func,
    input  logic [PAGE_W-1:0] in_first_page,
    input  logic [CNT_W-1:0]  in_run_length,
    input  bpfa_cmd_t         cmd,
    output bpfa_status_t      status,
    output logic              out_granted,
    output logic [PAGE_W-1:0] out_granted_page,
    output logic [CNT_W-1:0]  out_free_pages,
    output logic [CNT_W-1:0]  out_used_pages,
    output logic [CNT_W-1:0]  out_reserved_pages
);

    localparam int DEPTH = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
    localparam int AW    = $clog2(DEPTH);
    localparam int POP_W = $clog2(WORD_BITS + 1);

    localparam word_t ALL_ONES = '1;

    typedef logic [AW-1:0] addr_t;

    function automatic logic [POP_W-1:0] popcount(input word_t w);
        logic [POP_W-1:0] n;
        n = '0;
        for (int i = 0; i < WORD_BITS; i++) begin
            n = n + POP_W'(w[i]);
        end
        return n;
    endfunction

    function automatic logic [BIT_W-1:0] lowest_bit(input word_t w);
        logic [BIT_W-1:0] idx;
        idx = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (w[i]) begin
                idx = BIT_W'(i);
            end
        end
        return idx;
    endfunction

    word_t             mem [DEPTH];
    word_t             rdata_reg;

    cnt_t              total_reg;
    cnt_t              hint_reg;
    cnt_t              used_reg;
    cnt_t              reserved_reg;
    logic [FUNC_W-1:0] func_reg;
    logic [PAGE_W-1:0] first_reg;
    cnt_t              len_reg;
    cnt_t              lo_reg;
    cnt_t              last_reg;
    addr_t             addr_reg;
    logic              granted_reg;
    logic [PAGE_W-1:0] page_reg;
    logic              pend_valid_reg;
    logic [POP_W-1:0]  pend_pop_reg;
    logic              res_granted_reg;
    logic [PAGE_W-1:0] res_page_reg;
    cnt_t              res_free_reg;
    cnt_t              res_used_reg;
    cnt_t              res_reserved_reg;

    cnt_t              lim;
    logic              is_req;
    logic              is_run;
    logic              is_set;
    logic              cnt_used;
    logic              cnt_up;
    logic [CNT_W:0]    run_sum;
    cnt_t              run_end;
    cnt_t              start_lo;
    cnt_t              start_end;
    addr_t             lo_word;
    addr_t             last_word;
    logic              at_last;
    word_t             lo_mask;
    word_t             hi_mask;
    word_t             mask;
    word_t             cand_free;
    word_t             cand_set;
    word_t             sel;
    logic              sel_any;
    logic [BIT_W-1:0]  sel_bit;
    cnt_t              sel_idx;
    word_t             wdata;
    logic [POP_W-1:0]  pop;
    cnt_t              cnt_cur;
    cnt_t              cnt_new;
    logic [CNT_W:0]    cnt_sum;
    logic [CNT_W:0]    taken;

    assign lim = (32'(total_reg) < MAX_PAGES) ? total_reg : CNT_W'(MAX_PAGES);

    // operation decode
    always_comb begin
        is_req   = (func_reg == FN_REQUEST);
        is_run   = func_reg inside {FN_LOCK, FN_FREE, FN_RESERVE, FN_UNRESERVE};
        is_set   = func_reg inside {FN_REQUEST, FN_LOCK, FN_RESERVE};
        cnt_used = func_reg inside {FN_REQUEST, FN_LOCK, FN_FREE};
        cnt_up   = is_set;
    end

    // range setup: request scans from the hint to the limit
    always_comb begin
        run_sum   = {2'b00, first_reg} + {1'b0, len_reg};
        run_end   = (run_sum > {1'b0, lim}) ? lim : run_sum[CNT_W-1:0];
        start_lo  = is_req ? hint_reg : CNT_W'(first_reg);
        start_end = is_req ? lim : run_end;
    end

    assign status.empty = !(is_req || is_run) || (start_lo >= start_end);

    // word masking and bit selection
    always_comb begin
        lo_word   = AW'(lo_reg >> BIT_W);
        last_word = AW'(last_reg >> BIT_W);
        at_last   = (addr_reg == last_word);
        lo_mask   = (addr_reg == lo_word) ? (ALL_ONES << lo_reg[BIT_W-1:0]) : ALL_ONES;
        hi_mask   = at_last ?
                    (ALL_ONES >> (BIT_W'(WORD_BITS - 1) - last_reg[BIT_W-1:0])) : ALL_ONES;
        mask      = lo_mask & hi_mask;
        cand_free = ~rdata_reg & mask;
        cand_set  = rdata_reg & mask;
        sel       = is_set ? cand_free : cand_set;
        sel_any   = |sel;
        sel_bit   = lowest_bit(sel);
        sel_idx   = CNT_W'({addr_reg, sel_bit});

        if (is_req) begin
            wdata = rdata_reg | (word_t'(sel_any) << sel_bit);
            pop   = POP_W'(sel_any);
        end else if (is_set) begin
            wdata = rdata_reg | mask;
            pop   = popcount(cand_free);
        end else begin
            wdata = rdata_reg & ~mask;
            pop   = popcount(cand_set);
        end
    end

    assign status.mod_done = at_last || (is_req && sel_any);
    assign status.clr_last = (addr_reg == AW'(DEPTH - 1));

    // saturating counter update from the previous modify step
    always_comb begin
        cnt_cur = cnt_used ? used_reg : reserved_reg;
        cnt_sum = {1'b0, cnt_cur} + (CNT_W + 1)'(pend_pop_reg);
        if (cnt_up) begin
            cnt_new = (cnt_sum > {1'b0, CNT_MAX}) ? CNT_MAX : cnt_sum[CNT_W-1:0];
        end else begin
            cnt_new = (cnt_cur > CNT_W'(pend_pop_reg)) ? cnt_cur - CNT_W'(pend_pop_reg) : '0;
        end
        taken = {1'b0, used_reg} + {1'b0, reserved_reg};
    end

    // bitmap memory
    always_ff @(posedge aclk) begin
        if (cmd.clear) begin
            mem[addr_reg] <= '0;
        end else if (cmd.modify) begin
            mem[addr_reg] <= wdata;
        end
        rdata_reg <= mem[addr_reg];
    end

    // control-side state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg      <= TOTAL_RESET;
            hint_reg       <= '0;
            used_reg       <= '0;
            reserved_reg   <= '0;
            addr_reg       <= '0;
            pend_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                total_reg <= cfg_data;
            end

            pend_valid_reg <= cmd.modify;
            if (pend_valid_reg) begin
                if (cnt_used) begin
                    used_reg <= cnt_new;
                end else begin
                    reserved_reg <= cnt_new;
                end
            end

            if (cmd.clear) begin
                addr_reg <= addr_reg + 1'b1;
            end else if (cmd.start) begin
                addr_reg <= AW'(start_lo >> BIT_W);
                if (is_req && status.empty) begin
                    hint_reg <= lim;
                end
            end else if (cmd.modify) begin
                if (!status.mod_done) begin
                    addr_reg <= addr_reg + 1'b1;
                end
                if (is_req) begin
                    if (sel_any) begin
                        hint_reg <= sel_idx;
                    end else if (at_last) begin
                        hint_reg <= lim;
                    end
                end else if (!is_set && sel_any && (sel_idx < hint_reg)) begin
                    hint_reg <= sel_idx;
                end
            end
        end
    end

    // item and range payload
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            func_reg    <= in_func;
            first_reg   <= in_first_page;
            len_reg     <= in_run_length;
            granted_reg <= 1'b0;
            page_reg    <= '0;
        end
        if (cmd.start) begin
            lo_reg   <= start_lo;
            last_reg <= start_end - 1'b1;
        end
        if (cmd.modify) begin
            pend_pop_reg <= pop;
            if (is_req && sel_any) begin
                granted_reg <= 1'b1;
                page_reg    <= PAGE_W'(sel_idx);
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            res_granted_reg  <= granted_reg;
            res_page_reg     <= page_reg;
            res_free_reg     <= ({1'b0, lim} > taken) ? lim - taken[CNT_W-1:0] : '0;
            res_used_reg     <= used_reg;
            res_reserved_reg <= reserved_reg;
        end
    end

    assign out_granted        = res_granted_reg;
    assign out_granted_page   = res_page_reg;
    assign out_free_pages     = res_free_reg;
    assign out_used_pages     = res_used_reg;
    assign out_reserved_pages = res_reserved_reg;

endmodule

FILE: rtl/bitmap_page_frame_allocator_core.sv
// ----------------------------------------------------------------------------
// bitmap_page_frame_allocator_core
// Next-fit bitmap page frame allocator with one bit per page frame. Each
// item is a request, lock, free, reserve or unreserve (other function codes
// change nothing); each produces one result item with the grant and the free,
// used and reserved page counts. The bitmap sits in a memory of 32-bit words
// that takes one read and one write per cycle, and every request or run
// walks it word by word with a read step and a modify step: a request
// walks every word from the search hint to the first free page, a run every
// word it covers, and an item with nothing to touch skips the walk. After
// reset a clearing sweep zeroes all ceil(MAX_PAGES / 32) words (2048 at the
// default), one word per cycle, before the first item is taken; writes of
// total_pages are taken at any time through the configuration channel.
// A finished result waits in the output register while the next item runs.
// ----------------------------------------------------------------------------
module bitmap_page_frame_allocator_core
    import bpfa_pkg::*;
#(
    parameter int MAX_PAGES = DEF_MAX_PAGES
) (
    input  logic             aclk,
    input  logic             aresetn,

    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CNT_W-1:0] cfg_data,    // total_pages

    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [39:0]      s_tdata,     // first_page[15:0], run_length[32:16], zero fill
    input  logic [2:0]       s_tuser,     // func

    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [71:0]      m_tdata,     // granted_page[15:0], free_pages[32:16],
                                          // used_pages[49:33], reserved_pages[66:50], zero fill
    output logic [0:0]       m_tuser      // granted
);

    bpfa_cmd_t         cmd;
    bpfa_status_t      status;
    logic              granted;
    logic [PAGE_W-1:0] granted_page;
    logic [CNT_W-1:0]  free_pages;
    logic [CNT_W-1:0]  used_pages;
    logic [CNT_W-1:0]  reserved_pages;

    assign cfg_ready = 1'b1;

    bpfa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    bpfa_datapath #(
        .MAX_PAGES (MAX_PAGES)
    ) u_datapath (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_valid          (cfg_valid),
        .cfg_data           (cfg_data),
        .in_func            (s_tuser),
        .in_first_page      (s_tdata[15:0]),
        .in_run_length      (s_tdata[32:16]),
        .cmd                (cmd),
        .status             (status),
        .out_granted        (granted),
        .out_granted_page   (granted_page),
        .out_free_pages     (free_pages),
        .out_used_pages     (used_pages),
        .out_reserved_pages (reserved_pages)
    );

    assign m_tdata = {5'b00000, reserved_pages, used_pages, free_pages, granted_page};
    assign m_tuser = granted;

endmodule

FILE: sim/frame_alloc_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// frame_alloc_checker
// Watches the configuration, request and result channels of the page frame
// allocator. It keeps its own bitmap, next-fit hint and page counts, predicts
// the result item of every accepted request item and compares it field by
// field with the result items that come out.
// ----------------------------------------------------------------------------
module frame_alloc_checker
    import bpfa_pkg::*;
#(
    parameter int MAX_PAGES = DEF_MAX_PAGES
) (
    input  logic             aclk,
    input  logic             aresetn,

    input  logic             cfg_valid,
    input  logic             cfg_ready,
    input  logic [CNT_W-1:0] cfg_data,

    input  logic             s_tvalid,
    input  logic             s_tready,
    input  logic [39:0]      s_tdata,     // first_page[15:0], run_length[32:16], zero fill
    input  logic [2:0]       s_tuser,     // func

    input  logic             m_tvalid,
    input  logic             m_tready,
    input  logic [71:0]      m_tdata,     // granted_page[15:0], free_pages[32:16],
                                          // used_pages[49:33], reserved_pages[66:50], zero fill
    input  logic [0:0]       m_tuser,     // granted

    output int               fail_count,
    output int               results_taken,
    output int               results_due
);

    typedef struct packed {
        logic              granted;
        logic [PAGE_W-1:0] page;
        cnt_t              free_cnt;
        cnt_t              used_cnt;
        cnt_t              rsv_cnt;
    } alloc_result_t;

    bit            frame_map [MAX_PAGES];
    int unsigned   hint;
    int unsigned   used_total;
    int unsigned   rsv_total;
    int unsigned   page_total;
    alloc_result_t alloc_expected_q [$];
    alloc_result_t want;
    int            errs;

    function automatic int unsigned sat_inc(int unsigned c);
        return (c < CNT_MAX) ? c + 1 : c;
    endfunction

    function automatic int unsigned sat_dec(int unsigned c);
        return (c > 0) ? c - 1 : c;
    endfunction

    // Apply one operation to the local bitmap and return the result item.
    function automatic alloc_result_t apply_frame_op(bpfa_func_t fn, logic [PAGE_W-1:0] first,
                                                     logic [CNT_W-1:0] len);
        alloc_result_t res;
        int unsigned   lim;
        int unsigned   stop;
        int unsigned   taken;
        bit            set_op;
        bit            on_used;
        res = '0;
        lim = (page_total < MAX_PAGES) ? page_total : MAX_PAGES;
        case (fn)
            FN_REQUEST: begin
                while (hint < lim && frame_map[hint])
                    hint++;
                if (hint < lim) begin
                    frame_map[hint] = 1'b1;
                    used_total = sat_inc(used_total);
                    res.granted = 1'b1;
                    res.page = hint[PAGE_W-1:0];
                end else begin
                    hint = lim;
                end
            end
            FN_LOCK, FN_FREE, FN_RESERVE, FN_UNRESERVE: begin
                set_op = (fn == FN_LOCK) || (fn == FN_RESERVE);
                on_used = (fn == FN_LOCK) || (fn == FN_FREE);
                stop = first + len;
                if (stop > lim)
                    stop = lim;
                for (int unsigned i = first; i < stop; i++) begin
                    if (set_op && !frame_map[i]) begin
                        frame_map[i] = 1'b1;
                        if (on_used)
                            used_total = sat_inc(used_total);
                        else
                            rsv_total = sat_inc(rsv_total);
                    end else if (!set_op && frame_map[i]) begin
                        frame_map[i] = 1'b0;
                        if (on_used)
                            used_total = sat_dec(used_total);
                        else
                            rsv_total = sat_dec(rsv_total);
                        if (hint > i)
                            hint = i;
                    end
                end
            end
            default: ;
        endcase
        taken = used_total + rsv_total;
        res.free_cnt = (lim > taken) ? CNT_W'(lim - taken) : '0;
        res.used_cnt = CNT_W'(used_total);
        res.rsv_cnt = CNT_W'(rsv_total);
        return res;
    endfunction

    function automatic int field_miss(string name, int unsigned want_v, int unsigned got_v);
        if (want_v != got_v) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want_v, got_v);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            foreach (frame_map[i])
                frame_map[i] = 1'b0;
            hint = 0;
            used_total = 0;
            rsv_total = 0;
            page_total = TOTAL_RESET;
            alloc_expected_q.delete();
            fail_count <= 0;
            results_taken <= 0;
            results_due <= 0;
        end else begin
            errs = 0;
            if (cfg_valid && cfg_ready)
                page_total = cfg_data;
            if (s_tvalid && s_tready)
                alloc_expected_q.push_back(apply_frame_op(bpfa_func_t'(s_tuser), s_tdata[15:0],
                                                          s_tdata[32:16]));
            if (m_tvalid && m_tready) begin
                results_taken <= results_taken + 1;
                if (alloc_expected_q.size() == 0) begin
                    $error("result item with nothing expected: granted %0d page %0d",
                           m_tuser[0], m_tdata[15:0]);
                    errs = 1;
                end else begin
                    want = alloc_expected_q.pop_front();
                    errs += field_miss("granted", want.granted, m_tuser[0]);
                    errs += field_miss("granted_page", want.page, m_tdata[15:0]);
                    errs += field_miss("free_pages", want.free_cnt, m_tdata[32:16]);
                    errs += field_miss("used_pages", want.used_cnt, m_tdata[49:33]);
                    errs += field_miss("reserved_pages", want.rsv_cnt, m_tdata[66:50]);
                end
            end
            results_due <= alloc_expected_q.size();
            fail_count <= fail_count + errs;
        end
    end

endmodule

FILE: sim/bitmap_page_frame_allocator_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bitmap_page_frame_allocator_core_tb
// Drives the page frame allocator with a directed set of operations and then
// random phases under several page-count settings, with random gaps on the
// request side and random stalls on the result side. A checker beside the
// block predicts every result item and counts mismatches.
// ----------------------------------------------------------------------------
module bitmap_page_frame_allocator_core_tb;
    import bpfa_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int TAIL_CYCLES    = 64;
    localparam int PHASE_ITEMS    = 200;
    localparam logic [FUNC_W-1:0] FN_UNUSED_FIRST = 3'd5;
    localparam logic [FUNC_W-1:0] FN_UNUSED_LAST  = 3'd7;
    localparam logic [CNT_W-1:0]  TOTAL_ALL_ONES  = '1;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [CNT_W-1:0] cfg_data = '0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [39:0]      s_tdata = '0;     // first_page[15:0], run_length[32:16], zero fill
    logic [2:0]       s_tuser = '0;     // func
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [71:0]      m_tdata;          // granted_page[15:0], free_pages[32:16],
                                        // used_pages[49:33], reserved_pages[66:50], zero fill
    logic [0:0]       m_tuser;          // granted

    int fail_count;
    int results_taken;
    int results_due;
    int items_sent = 0;
    int settings_done = 0;
    int s_gap_odds = 3;
    int m_stall_odds = 3;
    int stall_left = 0;
    int stuck = 0;

    int unsigned    phase_totals [9];
    logic [CNT_W-1:0] total_now;
    int unsigned    lim_now;
    int             n_items;

    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    bitmap_page_frame_allocator_core u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    frame_alloc_checker u_alloc_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .fail_count    (fail_count),
        .results_taken (results_taken),
        .results_due   (results_due)
    );

    // Result-side backpressure: random stall bursts.
    always @(posedge aclk) begin
        if (m_stall_odds == 0) begin
            m_tready <= 1'b1;
        end else if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, m_stall_odds) == 0) begin
            m_tready <= 1'b0;
            stall_left <= $urandom_range(0, 3);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // End the run when nothing has been accepted for too long.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            stuck <= 0;
        end else begin
            stuck <= stuck + 1;
            if (stuck >= WATCHDOG_LIMIT) begin
                $display("watchdog: no item accepted for %0d cycles", WATCHDOG_LIMIT);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    task automatic push_item(logic [2:0] fn, logic [PAGE_W-1:0] first, logic [CNT_W-1:0] len);
        if (s_gap_odds != 0 && $urandom_range(0, s_gap_odds) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= fn;
        s_tdata <= {7'b0, len, first};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        items_sent++;
    endtask

    // Hold off the request side until every result item is back.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (results_taken < items_sent)
            @(posedge aclk);
    endtask

    task automatic write_total(logic [CNT_W-1:0] value);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        cfg_valid <= 1'b0;
        settings_done++;
    endtask

    task automatic random_page_op(int unsigned lim);
        logic [2:0]        fn;
        logic [PAGE_W-1:0] first;
        logic [CNT_W-1:0]  len;
        int unsigned       pick;
        int unsigned       span;
        pick = $urandom_range(0, 99);
        if (pick < 36)
            fn = FN_REQUEST;
        else if (pick < 52)
            fn = FN_LOCK;
        else if (pick < 66)
            fn = FN_FREE;
        else if (pick < 78)
            fn = FN_RESERVE;
        else if (pick < 92)
            fn = FN_UNRESERVE;
        else
            fn = FUNC_W'($urandom_range(FN_UNUSED_FIRST, FN_UNUSED_LAST));
        span = lim + lim / 8 + 1;
        if (span > 65535)
            span = 65535;
        if ($urandom_range(0, 9) == 0)
            first = PAGE_W'($urandom);
        else
            first = PAGE_W'($urandom_range(0, span));
        pick = $urandom_range(0, 99);
        if (pick < 3)
            len = CNT_W'($urandom);
        else if (pick < 8)
            len = '0;
        else if (pick < 80)
            len = CNT_W'($urandom_range(1, 8));
        else
            len = CNT_W'($urandom_range(1, (lim > 512) ? 512 : lim + 1));
        push_item(fn, first, len);
    endtask

    initial begin
        phase_totals = '{64, 1, 0, 100, TOTAL_ALL_ONES, 33, 2048, 0, 65536};
        phase_totals[7] = $urandom_range(2, 65535);

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part at the reset page count.
        push_item(FN_REQUEST, 16'h0000, 17'h00000);
        push_item(FN_REQUEST, 16'hFFFF, 17'h1FFFF);
        push_item(FN_LOCK, 16'd0, 17'd0);
        push_item(FN_LOCK, 16'd10, 17'd5);
        push_item(FN_REQUEST, 16'd0, 17'd0);
        push_item(FN_RESERVE, 16'd12, 17'd8);
        // free over reserved pages drives used_pages down to zero and holds it there
        push_item(FN_FREE, 16'd0, 17'd20);
        push_item(FN_UNRESERVE, 16'd0, 17'd20);
        push_item(FN_UNUSED_FIRST, 16'h5555, 17'h0AAAA);
        push_item(FN_UNUSED_FIRST + 3'd1, 16'hAAAA, 17'h15555);
        push_item(FN_UNUSED_LAST, 16'hFFFF, 17'h1FFFF);
        push_item(FN_LOCK, 16'hFFFF, 17'h1FFFF);
        push_item(FN_RESERVE, 16'hFFC0, 17'h10000);
        push_item(FN_UNRESERVE, 16'hFFFF, 17'd1);
        push_item(FN_LOCK, 16'd0, 17'h10000);
        push_item(FN_REQUEST, 16'd0, 17'd0);
        push_item(FN_REQUEST, 16'd0, 17'd0);
        push_item(FN_FREE, 16'h8000, 17'd1);
        push_item(FN_REQUEST, 16'd0, 17'd0);
        drain_results();
        push_item(FN_FREE, 16'd0, 17'h1FFFF);
        push_item(FN_RESERVE, 16'hAAAA, 17'd3);
        push_item(FN_UNRESERVE, 16'd0, 17'h1FFFF);
        // leave more pages taken than the next setting has
        push_item(FN_LOCK, 16'd0, 17'd300);

        foreach (phase_totals[p]) begin
            total_now = CNT_W'(phase_totals[p]);
            write_total(total_now);
            lim_now = (total_now > DEF_MAX_PAGES) ? DEF_MAX_PAGES : total_now;
            if (p == $size(phase_totals) - 1) begin
                s_gap_odds = 0;
                m_stall_odds <= 0;
            end else begin
                s_gap_odds = (p % 3 == 2) ? 0 : ((p % 3 == 0) ? 3 : 7);
                m_stall_odds <= (p % 3 == 1) ? 0 : ((p % 3 == 0) ? 3 : 7);
            end
            n_items = (lim_now <= 1) ? 40 : PHASE_ITEMS;
            for (int k = 0; k < n_items; k++) begin
                if (k == n_items / 2 && (p == 3 || $urandom_range(0, 2) == 0))
                    drain_results();
                random_page_op(lim_now);
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Ran %0d operations under %0d page-count settings, from zero pages to beyond",
                 items_sent, settings_done);
        $display("the bitmap size, with runs past the limit and exhausted searches.");
        if (fail_count == 0 && results_due == 0) begin
            $display("Regression PASS");
        end else begin
            $display("%0d mismatches, %0d results still expected", fail_count, results_due);
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
